// ===== hdl/arh_pkg.sv =====
// Shared types, constants and round functions of the AES-round message hash.
// Used by every module in hdl/; depends on nothing.
package arh_pkg;

	localparam int BlockBits  = 128;
	localparam int QueueDepth = 4;
	localparam int QPtrBits   = $clog2(QueueDepth);
	localparam int QCntBits   = $clog2(QueueDepth + 1);

	localparam logic [63:0] SeedLow  = 64'hD88F2928F05FC9B2;
	localparam logic [63:0] SeedHigh = 64'hBCB004E872B2D102;

	// One queued block: seed already folded in on the first block of a message.
	typedef struct packed {
		logic [BlockBits-1:0] data;
		logic                 first;
		logic                 last;
	} arh_item_t;

	localparam logic [7:0] InvSbox [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] mul9(input logic [7:0] b);
		return xtime(xtime(xtime(b))) ^ b;
	endfunction

	function automatic logic [7:0] mul11(input logic [7:0] b);
		return xtime(xtime(xtime(b))) ^ xtime(b) ^ b;
	endfunction

	function automatic logic [7:0] mul13(input logic [7:0] b);
		return xtime(xtime(xtime(b))) ^ xtime(xtime(b)) ^ b;
	endfunction

	function automatic logic [7:0] mul14(input logic [7:0] b);
		return xtime(xtime(xtime(b))) ^ xtime(xtime(b)) ^ xtime(b);
	endfunction

	// Keep the low n bytes of a block, zero the rest.
	function automatic logic [BlockBits-1:0] tail_mask(input logic [3:0] n);
		logic [BlockBits-1:0] m;
		for (int i = 0; i < BlockBits / 8; i++) begin
			m[8*i +: 8] = (5'(i) < {1'b0, n}) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	// One decryption round, zero round key. Byte i sits at bits 8i+7:8i.
	function automatic logic [BlockBits-1:0] inv_round(input logic [BlockBits-1:0] s);
		logic [7:0]           t [16];
		logic [BlockBits-1:0] r;
		logic [7:0]           a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			for (int w = 0; w < 4; w++) begin
				t[w + 4*c] = InvSbox[s[8*(w + 4*((c + 4 - w) & 3)) +: 8]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c];
			a1 = t[4*c + 1];
			a2 = t[4*c + 2];
			a3 = t[4*c + 3];
			r[32*c      +: 8] = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
			r[32*c + 8  +: 8] = mul9(a0)  ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
			r[32*c + 16 +: 8] = mul13(a0) ^ mul9(a1)  ^ mul14(a2) ^ mul11(a3);
			r[32*c + 24 +: 8] = mul11(a0) ^ mul13(a1) ^ mul9(a2)  ^ mul14(a3);
		end
		return r;
	endfunction

endpackage

// ===== hdl/arh_if.sv =====
// Valid/ready channel interfaces for message blocks and hash results.
// Depends on nothing.
interface arh_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic [31:0] total_length;
	logic        is_last;
	logic [3:0]  tail_bytes;

	modport source (output valid, block_low, block_high, total_length, is_last, tail_bytes,
		input ready);
	modport sink (input valid, block_low, block_high, total_length, is_last, tail_bytes,
		output ready);
endinterface

interface arh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

// ===== hdl/arh_front.sv =====
// Front end: accepts message blocks, tracks framing, masks the tail, folds the seed.
// Depends on arh_pkg and arh_if.
module arh_front (
	input  logic                clk,
	input  logic                arst_n,
	arh_in_if.sink              item,
	input  logic                q_full,
	output logic                push,
	output arh_pkg::arh_item_t  push_item
);

	logic                          in_msg_q;
	logic [arh_pkg::BlockBits-1:0] blk;
	logic [arh_pkg::BlockBits-1:0] seed;

	assign item.ready = !q_full;
	assign push       = item.valid && item.ready;

	always_comb begin
		blk  = {item.block_high, item.block_low};
		if (item.is_last) begin
			blk = blk & arh_pkg::tail_mask(item.tail_bytes);
		end
		seed = {arh_pkg::SeedHigh, arh_pkg::SeedLow ^ {32'b0, item.total_length}};
		push_item.first = !in_msg_q;
		push_item.last  = item.is_last;
		push_item.data  = in_msg_q ? blk : (blk ^ seed);
	end

	// Open a message on any non-tail block, close it on the tail.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
		end else if (push) begin
			in_msg_q <= !item.is_last;
		end
	end

endmodule

// ===== hdl/arh_queue.sv =====
// Short FIFO of classified blocks between front and back end.
// Depends on arh_pkg.
module arh_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  arh_pkg::arh_item_t  push_item,
	input  logic                pop,
	output logic                full,
	output logic                empty,
	output arh_pkg::arh_item_t  head
);

	arh_pkg::arh_item_t             entries_q [arh_pkg::QueueDepth];
	logic [arh_pkg::QPtrBits-1:0]   wr_ptr_q;
	logic [arh_pkg::QPtrBits-1:0]   rd_ptr_q;
	logic [arh_pkg::QCntBits-1:0]   count_q;

	assign full  = (count_q == arh_pkg::QCntBits'(arh_pkg::QueueDepth));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= arh_pkg::QCntBits'(arh_pkg::QueueDepth))
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

// ===== hdl/arh_back.sv =====
// Back end: chains one inverse AES round per block and registers the hash.
// Depends on arh_pkg and arh_if.
module arh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  arh_pkg::arh_item_t  head,
	output logic                pop,
	arh_out_if.source           result
);

	logic [arh_pkg::BlockBits-1:0] state_q;
	logic [arh_pkg::BlockBits-1:0] mixed;
	logic [arh_pkg::BlockBits-1:0] next_state;
	logic                          out_valid_q;
	logic [63:0]                   hash_q;

	// Hold a tail block while the previous hash still waits.
	assign pop = !empty && (!head.last || !out_valid_q || result.ready);

	assign mixed      = head.first ? head.data : (state_q ^ head.data);
	assign next_state = arh_pkg::inv_round(mixed);

	assign result.valid      = out_valid_q;
	assign result.hash_value = hash_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			state_q <= next_state;
		end
		if (pop && head.last) begin
			hash_q <= next_state[63:0] ^ next_state[127:64];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_tail_gives_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |=> out_valid_q)
		else $error("tail block popped without a hash");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !(pop && head.last))
		else $error("pending hash overwritten");

endmodule

// ===== hdl/aes_round_message_hash_top.sv =====
// AES-round message hash, top level: front end, block queue, round back end.
// Depends on arh_pkg, arh_if, arh_front, arh_queue and arh_back.
// A tail block is held in the queue, then its hash is registered in hash_q in arh_back.
// Throughput: one block per cycle, unless an unread hash holds a tail block back.
// Reset (arst_n low, asynchronous): empty the queue, drop any pending hash, close the message.
module aes_round_message_hash_top (
	input  logic      clk,
	input  logic      arst_n,
	arh_in_if.sink    item,
	arh_out_if.source result
);

	// Handshake between the front end, the queue and the back end.
	logic               q_full;
	logic               q_empty;
	logic               push;
	logic               pop;
	arh_pkg::arh_item_t push_item;
	arh_pkg::arh_item_t head;

	// Front: take a block whenever the queue has room, mask the tail and
	// fold the seed and length into the first block of a message.
	arh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Queue: decouple block intake from result back-pressure.
	arh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	// Back: advance the 128-bit state by one round per block and register
	// the folded hash when the tail block goes through.
	arh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule
